// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds whenever the antecedent holds in the same cycle.
`define QFT_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
// Property holds in the cycle after the antecedent.
`define QFT_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define QFT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define QFT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/qft_pkg.sv =====
// ---------------------------------------------------------------------------
// QFT engine package
// Types, codes and rotation constants shared by the engine modules.
// ---------------------------------------------------------------------------
`default_nettype none
package qft_pkg;

  localparam int unsigned STATE_QUBITS_DEF = 10;
  localparam int unsigned AMP_WIDTH_DEF    = 32;
  localparam int unsigned QIDX_W           = 5;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 5;
  localparam int unsigned COEF_W           = 32;

  localparam logic signed [COEF_W-1:0] INV_SQRT2_Q30 = 32'sd759250125;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_QUBIT  = 2'd0,
    CFG_QUBIT_COUNT  = 2'd1,
    CFG_SWAP_ENABLE  = 2'd2,
    CFG_INVERSE_MODE = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_FETCH = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_READY = 2'd1,
    STATUS_BAD_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    GATE_HAD  = 2'd0,
    GATE_CPH  = 2'd1,
    GATE_SWAP = 2'd2
  } gate_kind_t;

  // Current gate as issued by the sequencer
  typedef struct packed {
    logic              valid;
    logic              done;
    gate_kind_t        kind;
    logic [QIDX_W-1:0] q1;
    logic [QIDX_W-1:0] q2;
    logic [QIDX_W-1:0] m;
    logic              neg;
  } gate_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clear;
    logic sub;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_SWAP, SQ_HAD, SQ_CPH, SQ_DONE
  } seq_state_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_GATE, ST_SCAN, ST_RDB, ST_CAPB,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_WR0, ST_WR1
  } eng_state_t;

  // cos(pi/2^m) in Q2.30
  function automatic logic signed [COEF_W-1:0] cos_q30(input logic [QIDX_W-1:0] m);
    logic signed [COEF_W-1:0] v;
    unique case (m)
      5'd0:  v = -32'sd1073741824;
      5'd1:  v = 32'sd0;
      5'd2:  v = 32'sd759250125;
      5'd3:  v = 32'sd992008094;
      5'd4:  v = 32'sd1053110176;
      5'd5:  v = 32'sd1068571464;
      5'd6:  v = 32'sd1072448455;
      5'd7:  v = 32'sd1073418433;
      5'd8:  v = 32'sd1073660973;
      5'd9:  v = 32'sd1073721611;
      5'd10: v = 32'sd1073736771;
      5'd11: v = 32'sd1073740561;
      5'd12: v = 32'sd1073741508;
      5'd13: v = 32'sd1073741745;
      5'd14: v = 32'sd1073741804;
      5'd15: v = 32'sd1073741819;
      5'd16: v = 32'sd1073741823;
      5'd17: v = 32'sd1073741824;
      5'd18: v = 32'sd1073741824;
      5'd19: v = 32'sd1073741824;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // sin(pi/2^m) in Q2.30
  function automatic logic signed [COEF_W-1:0] sin_q30(input logic [QIDX_W-1:0] m);
    logic signed [COEF_W-1:0] v;
    unique case (m)
      5'd0:  v = 32'sd0;
      5'd1:  v = 32'sd1073741824;
      5'd2:  v = 32'sd759250125;
      5'd3:  v = 32'sd410903207;
      5'd4:  v = 32'sd209476638;
      5'd5:  v = 32'sd105245103;
      5'd6:  v = 32'sd52686014;
      5'd7:  v = 32'sd26350943;
      5'd8:  v = 32'sd13176464;
      5'd9:  v = 32'sd6588356;
      5'd10: v = 32'sd3294193;
      5'd11: v = 32'sd1647099;
      5'd12: v = 32'sd823550;
      5'd13: v = 32'sd411775;
      5'd14: v = 32'sd205887;
      5'd15: v = 32'sd102944;
      5'd16: v = 32'sd51472;
      5'd17: v = 32'sd25736;
      5'd18: v = 32'sd12868;
      5'd19: v = 32'sd6434;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qft_mac.sv =====
// ---------------------------------------------------------------------------
// QFT shared multiply-accumulate unit
// One signed multiplier with accumulator, plus Q2.30 rounding and saturation.
// ---------------------------------------------------------------------------
`default_nettype none
module qft_mac
  import qft_pkg::*;
#(
  parameter int unsigned AMP_WIDTH = AMP_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire mac_ctl_t                    ctl_i,
  input  wire logic signed [AMP_WIDTH:0]   opa_i,
  input  wire logic signed [COEF_W-1:0]    coef_i,
  output logic signed [AMP_WIDTH-1:0]      rnd_o
);

  localparam int unsigned PROD_W = AMP_WIDTH + 1 + COEF_W;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam int unsigned Q_W    = ACC_W - 30;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  rsum;
  logic        [Q_W-1:0]    q;
  logic        [Q_W-AMP_WIDTH:0] hi;

  assign prod    = opa_i * coef_i;
  assign term    = ctl_i.sub ? -ACC_W'(prod) : ACC_W'(prod);
  assign base    = ctl_i.clear ? '0 : acc_r;
  assign acc_nxt = base + term;

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      acc_r <= acc_nxt;
    end
  end

  // round half up, floor shift by 30, saturate to the amplitude width
  assign rsum = acc_r + {{(ACC_W-30){1'b0}}, 1'b1, 29'd0};
  assign q    = rsum[ACC_W-1:30];
  assign hi   = q[Q_W-1:AMP_WIDTH-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      rnd_o = q[AMP_WIDTH-1:0];
    end else if (q[Q_W-1]) begin
      rnd_o = {1'b1, {(AMP_WIDTH-1){1'b0}}};
    end else begin
      rnd_o = {1'b0, {(AMP_WIDTH-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qft_gate_seq.sv =====
// ---------------------------------------------------------------------------
// QFT gate sequencer
// Walks the Hadamard, controlled-phase and swap list of one transform.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module qft_gate_seq
  import qft_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire logic              adv_i,
  input  wire logic [QIDX_W-1:0] first_qubit_i,
  input  wire logic [QIDX_W-1:0] qubit_count_i,
  input  wire logic              swap_en_i,
  input  wire logic              inverse_i,
  output gate_t                  gate_o
);

  seq_state_t        state_r, state_nxt;
  logic [QIDX_W-1:0] k_r, k_nxt;
  logic [QIDX_W-1:0] n_r, n_nxt;
  logic              sw_r, sw_nxt;
  logic              inv_r, inv_nxt;
  logic [QIDX_W-1:0] gi_r, gi_nxt;
  logic [QIDX_W-1:0] gj_r, gj_nxt;
  logic [QIDX_W-1:0] si_r, si_nxt;

  logic [QIDX_W-1:0] half;
  logic [QIDX_W:0]   kn;
  logic [QIDX_W:0]   gi1, gj1, si1;
  logic [QIDX_W:0]   q1w, q2w;
  logic              q_in_range;

  assign half = n_r >> 1;
  assign kn   = {1'b0, k_r} + {1'b0, n_r};
  assign gi1  = {1'b0, gi_r} + 6'd1;
  assign gj1  = {1'b0, gj_r} + 6'd1;
  assign si1  = {1'b0, si_r} + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    n_r   <= n_nxt;
    sw_r  <= sw_nxt;
    inv_r <= inv_nxt;
    gi_r  <= gi_nxt;
    gj_r  <= gj_nxt;
    si_r  <= si_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    sw_nxt    = sw_r;
    inv_nxt   = inv_r;
    gi_nxt    = gi_r;
    gj_nxt    = gj_r;
    si_nxt    = si_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (start_i) begin
          k_nxt   = first_qubit_i;
          n_nxt   = qubit_count_i;
          sw_nxt  = swap_en_i;
          inv_nxt = inverse_i;
          si_nxt  = '0;
          if (inverse_i) begin
            gi_nxt    = '0;
            state_nxt = (swap_en_i && (qubit_count_i >> 1) != '0) ? SQ_SWAP : SQ_HAD;
          end else begin
            gi_nxt    = QIDX_W'(1);
            state_nxt = SQ_HAD;
          end
        end
      end
      SQ_SWAP: begin
        if (adv_i) begin
          if (si1 < {1'b0, half}) begin
            si_nxt = si1[QIDX_W-1:0];
          end else if (inv_r) begin
            gi_nxt    = '0;
            state_nxt = SQ_HAD;
          end else begin
            state_nxt = SQ_DONE;
          end
        end
      end
      SQ_HAD: begin
        if (adv_i) begin
          if (!inv_r) begin
            if (gi_r < n_r) begin
              gj_nxt    = '0;
              state_nxt = SQ_CPH;
            end else if (sw_r && half != '0) begin
              si_nxt    = '0;
              state_nxt = SQ_SWAP;
            end else begin
              state_nxt = SQ_DONE;
            end
          end else if (gi1 < {1'b0, n_r}) begin
            gj_nxt    = gi1[QIDX_W-1:0];
            state_nxt = SQ_CPH;
          end else begin
            state_nxt = SQ_DONE;
          end
        end
      end
      SQ_CPH: begin
        if (adv_i) begin
          if (gj1 < (inv_r ? {1'b0, n_r} : {1'b0, gi_r})) begin
            gj_nxt = gj1[QIDX_W-1:0];
          end else begin
            gi_nxt    = gi1[QIDX_W-1:0];
            state_nxt = SQ_HAD;
          end
        end
      end
      SQ_DONE: begin
        state_nxt = SQ_IDLE;
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  // gate decode from the loop counters
  always_comb begin
    q1w = '0;
    q2w = '0;
    gate_o       = '0;
    gate_o.neg   = inv_r;
    gate_o.valid = (state_r == SQ_SWAP) || (state_r == SQ_HAD) || (state_r == SQ_CPH);
    gate_o.done  = (state_r == SQ_DONE);
    gate_o.kind  = GATE_HAD;
    unique case (state_r)
      SQ_SWAP: begin
        gate_o.kind = GATE_SWAP;
        q1w = {1'b0, k_r} + {1'b0, si_r};
        q2w = kn - 6'd1 - {1'b0, si_r};
      end
      SQ_HAD: begin
        q1w = inv_r ? ({1'b0, k_r} + {1'b0, gi_r}) : (kn - {1'b0, gi_r});
        q2w = q1w;
      end
      SQ_CPH: begin
        gate_o.kind = GATE_CPH;
        if (inv_r) begin
          q1w      = {1'b0, k_r} + {1'b0, gi_r};
          q2w      = {1'b0, k_r} + {1'b0, gj_r};
          gate_o.m = gj_r - gi_r;
        end else begin
          q1w      = kn - {1'b0, gi_r} - 6'd1;
          q2w      = kn - {1'b0, gj_r} - 6'd1;
          gate_o.m = gi_r - gj_r;
        end
      end
      default: begin
        q1w = '0;
        q2w = '0;
      end
    endcase
    gate_o.q1 = q1w[QIDX_W-1:0];
    gate_o.q2 = q2w[QIDX_W-1:0];
  end

  assign q_in_range = (q1w < kn) && (q2w < kn) && (q1w >= {1'b0, k_r}) && (q2w >= {1'b0, k_r});

  `QFT_ASSERT_IMP(a_pair_distinct, clk, rst_n, gate_o.valid && gate_o.kind != GATE_HAD, gate_o.q1 != gate_o.q2)
  `QFT_ASSERT_IMP(a_angle_nonzero, clk, rst_n, gate_o.valid && gate_o.kind == GATE_CPH, gate_o.m != '0)
  `QFT_ASSERT_IMP(a_qubit_range, clk, rst_n, gate_o.valid, q_in_range)
  `QFT_ASSERT_NXT(a_done_returns, clk, rst_n, gate_o.done, state_r == SQ_IDLE)

endmodule
`default_nettype wire

// ===== hw/rtl/quantum_fourier_transform_engine_top.sv =====
// ---------------------------------------------------------------------------
// Quantum Fourier transform engine, top level
// State-vector store, load/fetch control and gate sweep over the store.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel carries one word per handshake. A load word writes the
//   next amplitude of the store in index order; the word that fills the last
//   entry starts the transform over the configured qubit range. A fetch word
//   returns the next transformed amplitude, with out_last on the final one.
//   Loads give no result, except that a frame-completing load with a bad
//   qubit range returns status 2 and leaves the store as loaded. A fetch with
//   no transformed frame returns status 1.
// Transform sweep:
//   A load writes the store directly; a fetch goes through the registered
//   store read. The transform runs gate by gate through one shared
//   multiply-accumulate unit and a store with one write and one read port,
//   sweeping all 2^STATE_QUBITS indices per gate: each Hadamard pair is
//   read, scaled and written back, each phased entry is rotated in place and
//   each swapped pair is exchanged. The input is held off throughout.
// Reset and stalls:
//   Synchronous active-low reset clears the indices and the ready flag and
//   sets the configuration to its defaults; store contents are undefined
//   until loaded. A stalled result holds in the output register and blocks
//   only new input words. Configuration writes are taken in every cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module quantum_fourier_transform_engine_top
  import qft_pkg::*;
#(
  parameter int unsigned STATE_QUBITS = STATE_QUBITS_DEF,
  parameter int unsigned AMP_WIDTH    = AMP_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_kind,
  input  wire logic [31:0]           in_amp_real,
  input  wire logic [31:0]           in_amp_imag,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                out_real,
  output logic [31:0]                out_imag,
  output logic                       out_last,
  output logic [1:0]                 out_status,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned ADDR_W = STATE_QUBITS;
  localparam int unsigned DIM    = 1 << STATE_QUBITS;
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned WORD_W = 2 * AMP_WIDTH;

  // configuration registers
  logic [QIDX_W-1:0] first_qubit_r;
  logic [QIDX_W-1:0] qubit_count_r;
  logic              swap_enable_r;
  logic              inverse_mode_r;

  // amplitude store: {real, imag} per entry
  logic [WORD_W-1:0] mem [DIM];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata;

  eng_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] load_idx_r, load_idx_nxt;
  logic [ADDR_W-1:0] fetch_idx_r, fetch_idx_nxt;
  logic              frame_ready_r, frame_ready_nxt;
  logic [CNT_W-1:0]  x_r, x_nxt;
  logic [WORD_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic signed [AMP_WIDTH-1:0] res0_r, res0_nxt, res1_r, res1_nxt, res2_r, res2_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [AMP_WIDTH-1:0] out_real_r, out_real_nxt;
  logic signed [AMP_WIDTH-1:0] out_imag_r, out_imag_nxt;
  logic                        out_last_r, out_last_nxt;
  status_t                     out_status_r, out_status_nxt;

  logic in_acc;
  logic bad_range;

  // sequencer and shared unit hookup
  gate_t    gate;
  logic     seq_start, seq_adv;
  mac_ctl_t mac_ctl;
  logic signed [AMP_WIDTH:0]   opa;
  logic signed [COEF_W-1:0]    coef;
  logic signed [AMP_WIDTH-1:0] rnd;

  // sweep decode
  logic [ADDR_W-1:0] x, y, b1, b2, mask;
  logic              x_end, relevant;
  logic signed [AMP_WIDTH-1:0] a_re, a_im, b_re, b_im;
  logic signed [AMP_WIDTH:0]   sum_re, sum_im, dif_re, dif_im;
  logic signed [COEF_W-1:0]    c_coef, s_coef, s_raw;

  qft_gate_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_i       (seq_start),
    .adv_i         (seq_adv),
    .first_qubit_i (first_qubit_r),
    .qubit_count_i (qubit_count_r),
    .swap_en_i     (swap_enable_r),
    .inverse_i     (inverse_mode_r),
    .gate_o        (gate)
  );

  qft_mac #(
    .AMP_WIDTH (AMP_WIDTH)
  ) u_mac (
    .clk    (clk),
    .ctl_i  (mac_ctl),
    .opa_i  (opa),
    .coef_i (coef),
    .rnd_o  (rnd)
  );

  // configuration port: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_qubit_r  <= '0;
      qubit_count_r  <= QIDX_W'(1);
      swap_enable_r  <= 1'b1;
      inverse_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_QUBIT:  first_qubit_r  <= cfg_data;
        CFG_QUBIT_COUNT:  qubit_count_r  <= cfg_data;
        CFG_SWAP_ENABLE:  swap_enable_r  <= cfg_data[0];
        CFG_INVERSE_MODE: inverse_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign bad_range = (qubit_count_r == '0) ||
                     (({1'b0, first_qubit_r} + {1'b0, qubit_count_r}) > (QIDX_W+1)'(STATE_QUBITS));

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  // index decode for the current gate
  assign x     = x_r[ADDR_W-1:0];
  assign x_end = x_r[ADDR_W];
  assign b1    = ADDR_W'(1) << gate.q1;
  assign b2    = ADDR_W'(1) << gate.q2;
  assign mask  = b1 | b2;
  assign y     = (gate.kind == GATE_SWAP) ? (x ^ b1 ^ b2) : (x | b1);

  always_comb begin
    unique case (gate.kind)
      GATE_HAD:  relevant = !(|(x & b1));
      GATE_CPH:  relevant = ((x & mask) == mask);
      GATE_SWAP: relevant = (|(x & b1)) && !(|(x & b2));
      default:   relevant = 1'b0;
    endcase
  end

  assign a_re   = a_r[WORD_W-1:AMP_WIDTH];
  assign a_im   = a_r[AMP_WIDTH-1:0];
  assign b_re   = b_r[WORD_W-1:AMP_WIDTH];
  assign b_im   = b_r[AMP_WIDTH-1:0];
  assign sum_re = (AMP_WIDTH+1)'(a_re) + (AMP_WIDTH+1)'(b_re);
  assign sum_im = (AMP_WIDTH+1)'(a_im) + (AMP_WIDTH+1)'(b_im);
  assign dif_re = (AMP_WIDTH+1)'(a_re) - (AMP_WIDTH+1)'(b_re);
  assign dif_im = (AMP_WIDTH+1)'(a_im) - (AMP_WIDTH+1)'(b_im);
  assign c_coef = cos_q30(gate.m);
  assign s_raw  = sin_q30(gate.m);
  assign s_coef = gate.neg ? -s_raw : s_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      load_idx_r    <= '0;
      fetch_idx_r   <= '0;
      frame_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      load_idx_r    <= load_idx_nxt;
      fetch_idx_r   <= fetch_idx_nxt;
      frame_ready_r <= frame_ready_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    res0_r       <= res0_nxt;
    res1_r       <= res1_nxt;
    res2_r       <= res2_nxt;
    out_real_r   <= out_real_nxt;
    out_imag_r   <= out_imag_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    load_idx_nxt    = load_idx_r;
    fetch_idx_nxt   = fetch_idx_r;
    frame_ready_nxt = frame_ready_r;
    x_nxt           = x_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    res0_nxt        = res0_r;
    res1_nxt        = res1_r;
    res2_nxt        = res2_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_real_nxt    = out_real_r;
    out_imag_nxt    = out_imag_r;
    out_last_nxt    = out_last_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    waddr           = x;
    wdata           = {res0_r, rnd};
    raddr           = x;
    mac_ctl         = '0;
    opa             = '0;
    coef            = '0;
    seq_start       = 1'b0;
    seq_adv         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_t'(in_kind) == KIND_LOAD) begin
            mem_we          = 1'b1;
            waddr           = load_idx_r;
            wdata           = {in_amp_real[AMP_WIDTH-1:0], in_amp_imag[AMP_WIDTH-1:0]};
            frame_ready_nxt = 1'b0;
            fetch_idx_nxt   = '0;
            load_idx_nxt    = load_idx_r + ADDR_W'(1);
            if (&load_idx_r) begin
              if (bad_range) begin
                out_valid_nxt  = 1'b1;
                out_real_nxt   = '0;
                out_imag_nxt   = '0;
                out_last_nxt   = 1'b0;
                out_status_nxt = STATUS_BAD_RANGE;
              end else begin
                seq_start = 1'b1;
                state_nxt = ST_GATE;
              end
            end
          end else if (!frame_ready_r) begin
            out_valid_nxt  = 1'b1;
            out_real_nxt   = '0;
            out_imag_nxt   = '0;
            out_last_nxt   = 1'b0;
            out_status_nxt = STATUS_NOT_READY;
          end else begin
            raddr     = fetch_idx_r;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        out_valid_nxt  = 1'b1;
        out_real_nxt   = rdata_r[WORD_W-1:AMP_WIDTH];
        out_imag_nxt   = rdata_r[AMP_WIDTH-1:0];
        out_last_nxt   = &fetch_idx_r;
        out_status_nxt = STATUS_OK;
        fetch_idx_nxt  = fetch_idx_r + ADDR_W'(1);
        if (&fetch_idx_r) begin
          frame_ready_nxt = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      ST_GATE: begin
        if (gate.done) begin
          frame_ready_nxt = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (gate.valid) begin
          x_nxt     = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (x_end) begin
          seq_adv   = 1'b1;
          state_nxt = ST_GATE;
        end else if (relevant) begin
          raddr     = x;
          state_nxt = ST_RDB;
        end else begin
          x_nxt = x_r + CNT_W'(1);
        end
      end
      ST_RDB: begin
        a_nxt = rdata_r;
        if (gate.kind == GATE_CPH) begin
          state_nxt = ST_MUL0;
        end else begin
          raddr     = y;
          state_nxt = ST_CAPB;
        end
      end
      ST_CAPB: begin
        b_nxt     = rdata_r;
        state_nxt = (gate.kind == GATE_SWAP) ? ST_WR0 : ST_MUL0;
      end
      ST_MUL0: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b1;
        if (gate.kind == GATE_HAD) begin
          opa  = sum_re;
          coef = INV_SQRT2_Q30;
        end else begin
          opa  = (AMP_WIDTH+1)'(a_re);
          coef = c_coef;
        end
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        mac_ctl.en = 1'b1;
        if (gate.kind == GATE_HAD) begin
          res0_nxt      = rnd;
          mac_ctl.clear = 1'b1;
          opa           = sum_im;
          coef          = INV_SQRT2_Q30;
        end else begin
          mac_ctl.sub = 1'b1;
          opa         = (AMP_WIDTH+1)'(a_im);
          coef        = s_coef;
        end
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b1;
        if (gate.kind == GATE_HAD) begin
          res1_nxt = rnd;
          opa      = dif_re;
          coef     = INV_SQRT2_Q30;
        end else begin
          res0_nxt = rnd;
          opa      = (AMP_WIDTH+1)'(a_re);
          coef     = s_coef;
        end
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        mac_ctl.en = 1'b1;
        res2_nxt   = rnd;
        if (gate.kind == GATE_HAD) begin
          mac_ctl.clear = 1'b1;
          opa           = dif_im;
          coef          = INV_SQRT2_Q30;
        end else begin
          opa  = (AMP_WIDTH+1)'(a_im);
          coef = c_coef;
        end
        state_nxt = ST_WR0;
      end
      ST_WR0: begin
        mem_we = 1'b1;
        waddr  = x;
        unique case (gate.kind)
          GATE_SWAP: wdata = b_r;
          GATE_HAD:  wdata = {res0_r, res1_r};
          GATE_CPH:  wdata = {res0_r, rnd};
          default:   wdata = {res0_r, rnd};
        endcase
        if (gate.kind == GATE_CPH) begin
          x_nxt     = x_r + CNT_W'(1);
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_WR1;
        end
      end
      ST_WR1: begin
        mem_we    = 1'b1;
        waddr     = y;
        wdata     = (gate.kind == GATE_SWAP) ? a_r : {res2_r, rnd};
        x_nxt     = x_r + CNT_W'(1);
        state_nxt = ST_SCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_real   = 32'(out_real_r);
  assign out_imag   = 32'(out_imag_r);
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  `QFT_ASSERT_IMP(a_frame_quiet, clk, rst_n, frame_ready_r, state_r == ST_IDLE || state_r == ST_FETCH)
  `QFT_ASSERT_IMP(a_sweep_bound, clk, rst_n, x_end && state_r == ST_SCAN, x_r[ADDR_W-1:0] == '0)
  `QFT_ASSERT_IMP(a_error_blank, clk, rst_n, out_valid_r && out_status_r != STATUS_OK, out_real_r == '0 && out_imag_r == '0 && !out_last_r)
  `QFT_ASSERT_IMP(a_done_in_gate, clk, rst_n, gate.done, state_r == ST_GATE)
  `QFT_ASSERT_NXT(a_start_runs, clk, rst_n, seq_start, gate.valid && state_r == ST_GATE)

endmodule
`default_nettype wire
